/* hw/rtl/cwct_pkg.sv */
// ----------------------------------------------------------------------------
// cwct_pkg
// Types and constants shared by the clock with countdown timer.
// ----------------------------------------------------------------------------
package cwct_pkg;

  // One tick: the three button levels, 1 = pressed.
  typedef struct packed {
    logic minute_button;
    logic hour_button;
    logic mode_button;
  } in_item_t;

  // State after the tick.
  typedef struct packed {
    logic [4:0] clock_hours;
    logic [5:0] clock_minutes;
    logic [5:0] clock_seconds;
    logic [4:0] countdown_hours;
    logic [5:0] countdown_minutes;
    logic [5:0] countdown_seconds;
    logic       in_timer_mode;
    logic       countdown_running;
    logic       buzzer_on;
  } out_item_t;

  // Configuration register indexes.
  localparam logic [7:0] REG_WAIT_COUNT  = 8'd0;
  localparam logic [7:0] REG_BUZZ_LENGTH = 8'd1;

  // Button slots in the debounce arrays.
  localparam int BTN_MINUTE = 0;
  localparam int BTN_HOUR   = 1;
  localparam int BTN_MODE   = 2;
  localparam int NUM_BTN    = 3;

  localparam logic [5:0] SECS_MAX      = 6'd59;
  localparam logic [5:0] MINS_PER_HOUR = 6'd60;
  localparam logic [4:0] HOURS_PER_DAY = 5'd24;

  localparam logic [4:0] RESET_HOURS   = 5'd3;
  localparam logic [5:0] RESET_MINUTES = 6'd34;
  localparam logic [7:0] RESET_WAIT    = 8'd5;
  localparam logic [7:0] RESET_BUZZ    = 8'd3;

endpackage

/* hw/rtl/clock_with_countdown_timer_core.sv */
// ----------------------------------------------------------------------------
// clock_with_countdown_timer_core
// Time-of-day clock with debounced buttons, a countdown timer and a buzzer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): one item per tick, carrying
//   the minute, hour and mode button levels. The item is taken at a clock edge
//   with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall / out_data): one item per input
//   item, holding the clock, the countdown, the mode flags and the buzzer
//   drive as they stand after that tick.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   register 0 is the debounce threshold, register 1 the buzzer length.
//   cfg_ready is always high; write only while no item is in flight.
// Timing and throughput:
//   A result appears in the cycle after its item is taken. One item per cycle
//   is sustained while out_stall is low; the whole tick update is one pass of
//   logic into the state and result registers.
// Reset (rst, synchronous): the clock reads 03:34:00, the countdown is zero,
//   clock mode, buzzer idle, debounce counters cleared, registers at 5 and 3.
// Stall: while a result waits under out_stall, in_stall is raised and the
//   result register holds; a result taken in the same cycle frees the slot.
// ----------------------------------------------------------------------------
module clock_with_countdown_timer_core #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cwct_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cwct_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_index,
  input  logic [7:0]           cfg_data
);
  import cwct_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
  localparam logic [COUNT_WIDTH-1:0] RUN_MAX = {COUNT_WIDTH{1'b1}};

  logic [7:0] wait_count;
  logic [7:0] buzz_length;

  logic [4:0] hours_reg;
  logic [5:0] minutes_reg;
  logic [5:0] seconds_reg;
  logic [4:0] cd_hours_reg;
  logic [5:0] cd_minutes_reg;
  logic [5:0] cd_seconds_reg;
  logic       mode_flag;
  logic       running_flag;
  logic       buzz_active;
  logic [7:0] buzz_ticks_done;

  logic [COUNT_WIDTH-1:0] press_run   [NUM_BTN];
  logic [COUNT_WIDTH-1:0] release_run [NUM_BTN];
  logic [NUM_BTN-1:0]     press_latched;

  logic [COUNT_WIDTH-1:0] press_run_next   [NUM_BTN];
  logic [COUNT_WIDTH-1:0] release_run_next [NUM_BTN];
  logic [NUM_BTN-1:0]     press_latched_next;
  logic [NUM_BTN-1:0]     fire;
  logic [NUM_BTN-1:0]     level;

  logic [4:0] hours_next;
  logic [5:0] minutes_next;
  logic [5:0] seconds_next;
  logic [4:0] cd_hours_next;
  logic [5:0] cd_minutes_next;
  logic [5:0] cd_seconds_next;
  logic       mode_next;
  logic       running_next;
  logic       buzz_active_next;
  logic [7:0] buzz_ticks_next;
  logic       buzzer_next;

  logic accept;

  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign level[BTN_MINUTE] = in_data.minute_button;
  assign level[BTN_HOUR]   = in_data.hour_button;
  assign level[BTN_MODE]   = in_data.mode_button;

  // Debounce: a press fires once per latch; the latch clears after a long
  // enough release.
  always_comb begin
    for (int b = 0; b < NUM_BTN; b++) begin
      fire[b]               = 1'b0;
      press_run_next[b]     = press_run[b];
      release_run_next[b]   = release_run[b];
      press_latched_next[b] = press_latched[b];
      if (level[b]) begin
        if (press_run[b] != RUN_MAX) begin
          press_run_next[b] = press_run[b] + 1'b1;
        end
        release_run_next[b] = '0;
        if (CMP_W'(press_run_next[b]) > CMP_W'(wait_count)) begin
          fire[b]               = ~press_latched[b];
          press_latched_next[b] = 1'b1;
          press_run_next[b]     = '0;
        end
      end else begin
        if (release_run[b] != RUN_MAX) begin
          release_run_next[b] = release_run[b] + 1'b1;
        end
        press_run_next[b] = '0;
        if (CMP_W'(release_run_next[b]) > CMP_W'(wait_count)) begin
          release_run_next[b]   = '0;
          press_latched_next[b] = 1'b0;
        end
      end
    end
  end

  // Tick update, in order: mode button, minute and hour buttons, countdown,
  // buzzer, then the clock second.
  always_comb begin
    hours_next       = hours_reg;
    minutes_next     = minutes_reg;
    seconds_next     = seconds_reg;
    cd_hours_next    = cd_hours_reg;
    cd_minutes_next  = cd_minutes_reg;
    cd_seconds_next  = cd_seconds_reg;
    mode_next        = mode_flag;
    running_next     = running_flag;
    buzz_active_next = buzz_active;
    buzz_ticks_next  = buzz_ticks_done;
    buzzer_next      = 1'b0;

    if (fire[BTN_MODE]) begin
      if (!mode_flag) begin
        mode_next = 1'b1;
      end else if (running_flag) begin
        cd_hours_next   = '0;
        cd_minutes_next = '0;
        cd_seconds_next = '0;
        running_next    = 1'b0;
        mode_next       = 1'b0;
      end else begin
        buzz_ticks_next = '0;
        running_next    = 1'b1;
      end
    end

    if (fire[BTN_MINUTE]) begin
      if (!mode_next) begin
        if (minutes_next < MINS_PER_HOUR) minutes_next = minutes_next + 6'd1;
      end else begin
        cd_minutes_next = (cd_minutes_next >= SECS_MAX) ? 6'd0 : cd_minutes_next + 6'd1;
      end
    end

    if (fire[BTN_HOUR]) begin
      if (!mode_next) begin
        if (hours_next < HOURS_PER_DAY) hours_next = hours_next + 5'd1;
      end else begin
        if (cd_hours_next < HOURS_PER_DAY) cd_hours_next = cd_hours_next + 5'd1;
      end
    end

    if (mode_next && running_next) begin
      if (cd_hours_next == '0 && cd_minutes_next == '0 && cd_seconds_next == '0) begin
        running_next     = 1'b0;
        mode_next        = 1'b0;
        buzz_active_next = 1'b1;
        buzz_ticks_next  = '0;
      end else begin
        if (cd_seconds_next != '0) cd_seconds_next = cd_seconds_next - 6'd1;
        // A borrow happens as soon as the seconds sit at zero.
        if (cd_seconds_next == '0 && cd_minutes_next != '0) begin
          cd_minutes_next = cd_minutes_next - 6'd1;
          cd_seconds_next = SECS_MAX;
        end
        if (cd_minutes_next == '0 && cd_hours_next != '0) begin
          cd_hours_next   = cd_hours_next - 5'd1;
          cd_minutes_next = SECS_MAX;
        end
      end
    end

    if (buzz_active_next) begin
      if (buzz_ticks_next < buzz_length) begin
        buzz_ticks_next = buzz_ticks_next + 8'd1;
        buzzer_next     = 1'b1;
      end else begin
        buzz_active_next = 1'b0;
      end
    end

    if (seconds_next < MINS_PER_HOUR) seconds_next = seconds_next + 6'd1;
    if (seconds_next == MINS_PER_HOUR) begin
      if (minutes_next < MINS_PER_HOUR) minutes_next = minutes_next + 6'd1;
      seconds_next = '0;
    end
    if (minutes_next == MINS_PER_HOUR) begin
      if (hours_next < HOURS_PER_DAY) hours_next = hours_next + 5'd1;
      minutes_next = '0;
    end
    if (hours_next == HOURS_PER_DAY) hours_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_count  <= RESET_WAIT;
      buzz_length <= RESET_BUZZ;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_WAIT_COUNT) wait_count <= cfg_data;
      if (cfg_index == REG_BUZZ_LENGTH) buzz_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hours_reg       <= RESET_HOURS;
      minutes_reg     <= RESET_MINUTES;
      seconds_reg     <= '0;
      cd_hours_reg    <= '0;
      cd_minutes_reg  <= '0;
      cd_seconds_reg  <= '0;
      mode_flag       <= 1'b0;
      running_flag    <= 1'b0;
      buzz_active     <= 1'b0;
      buzz_ticks_done <= '0;
      press_latched   <= '0;
      for (int b = 0; b < NUM_BTN; b++) begin
        press_run[b]   <= '0;
        release_run[b] <= '0;
      end
    end else if (accept) begin
      hours_reg       <= hours_next;
      minutes_reg     <= minutes_next;
      seconds_reg     <= seconds_next;
      cd_hours_reg    <= cd_hours_next;
      cd_minutes_reg  <= cd_minutes_next;
      cd_seconds_reg  <= cd_seconds_next;
      mode_flag       <= mode_next;
      running_flag    <= running_next;
      buzz_active     <= buzz_active_next;
      buzz_ticks_done <= buzz_ticks_next;
      press_latched   <= press_latched_next;
      for (int b = 0; b < NUM_BTN; b++) begin
        press_run[b]   <= press_run_next[b];
        release_run[b] <= release_run_next[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.clock_hours       <= hours_next;
      out_data.clock_minutes     <= minutes_next;
      out_data.clock_seconds     <= seconds_next;
      out_data.countdown_hours   <= cd_hours_next;
      out_data.countdown_minutes <= cd_minutes_next;
      out_data.countdown_seconds <= cd_seconds_next;
      out_data.in_timer_mode     <= mode_next;
      out_data.countdown_running <= running_next;
      out_data.buzzer_on         <= buzzer_next;
    end
  end

endmodule

/* dv/tb_clock_with_countdown_timer_core.sv */
// ----------------------------------------------------------------------------
// tb_clock_with_countdown_timer_core
// Self-checking testbench for the clock with countdown timer. Button items
// are driven through the input channel while the output channel stalls at
// random. Every accepted item also runs through a cycle-free model of the
// debouncers, clock, countdown and buzzer kept here, and each result the
// block returns is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_clock_with_countdown_timer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cwct_pkg::*;

  localparam int COUNT_WIDTH  = 8;
  localparam int RUN_MAX      = (1 << COUNT_WIDTH) - 1;
  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLDOFF_LEN  = 200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  clock_with_countdown_timer_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted state of the block, as it stands after reset.
  int unsigned debounce_limit = RESET_WAIT;
  int unsigned buzz_len       = RESET_BUZZ;
  int unsigned clk_h = RESET_HOURS;
  int unsigned clk_m = RESET_MINUTES;
  int unsigned clk_s = 0;
  int unsigned cd_h = 0;
  int unsigned cd_m = 0;
  int unsigned cd_s = 0;
  bit          timer_mode = 1'b0;
  bit          cd_running = 1'b0;
  bit          buzzing = 1'b0;
  int unsigned buzz_count = 0;
  int unsigned press_len[NUM_BTN]   = '{default: 0};
  int unsigned release_len[NUM_BTN] = '{default: 0};
  bit          press_held[NUM_BTN]  = '{default: 1'b0};

  out_item_t predicted_outputs[$];
  int        errors = 0;
  int        ticks_sent = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        holdoff_request = 0;
  int        holdoff_left = 0;

  // True when the button gives an accepted press that is not latched.
  function automatic bit button_fires(int b, bit level);
    bit fire;
    fire = 1'b0;
    if (level) begin
      if (press_len[b] < RUN_MAX) press_len[b]++;
      release_len[b] = 0;
      if (press_len[b] > debounce_limit) begin
        if (!press_held[b]) begin
          fire = 1'b1;
          press_held[b] = 1'b1;
        end
        press_len[b] = 0;
      end
    end else begin
      if (release_len[b] < RUN_MAX) release_len[b]++;
      press_len[b] = 0;
      if (release_len[b] > debounce_limit) begin
        release_len[b] = 0;
        press_held[b] = 1'b0;
      end
    end
    return fire;
  endfunction

  function automatic out_item_t clock_tick(in_item_t it);
    out_item_t r;
    bit        buzz_now;
    buzz_now = 1'b0;

    // The mode button sees the mode from the start of the tick.
    if (button_fires(BTN_MODE, it.mode_button)) begin
      if (!timer_mode) begin
        timer_mode = 1'b1;
      end else if (cd_running) begin
        cd_h = 0;
        cd_m = 0;
        cd_s = 0;
        cd_running = 1'b0;
        timer_mode = 1'b0;
      end else begin
        buzz_count = 0;
        cd_running = 1'b1;
      end
    end

    if (button_fires(BTN_MINUTE, it.minute_button)) begin
      if (!timer_mode) begin
        if (clk_m < MINS_PER_HOUR) clk_m++;
      end else begin
        cd_m = (cd_m >= SECS_MAX) ? 0 : cd_m + 1;
      end
    end

    if (button_fires(BTN_HOUR, it.hour_button)) begin
      if (!timer_mode) begin
        if (clk_h < HOURS_PER_DAY) clk_h++;
      end else begin
        if (cd_h < HOURS_PER_DAY) cd_h++;
      end
    end

    if (timer_mode && cd_running) begin
      if (cd_h == 0 && cd_m == 0 && cd_s == 0) begin
        cd_running = 1'b0;
        timer_mode = 1'b0;
        buzzing = 1'b1;
        buzz_count = 0;
      end else begin
        if (cd_s > 0) cd_s--;
        if (cd_s == 0 && cd_m > 0) begin
          cd_m--;
          cd_s = SECS_MAX;
        end
        if (cd_m == 0 && cd_h > 0) begin
          cd_h--;
          cd_m = SECS_MAX;
        end
      end
    end

    if (buzzing) begin
      if (buzz_count < buzz_len) begin
        buzz_count++;
        buzz_now = 1'b1;
      end else begin
        buzzing = 1'b0;
      end
    end

    // A minute already carried by the button swallows the second's carry.
    if (clk_s < MINS_PER_HOUR) clk_s++;
    if (clk_s == MINS_PER_HOUR) begin
      if (clk_m < MINS_PER_HOUR) clk_m++;
      clk_s = 0;
    end
    if (clk_m == MINS_PER_HOUR) begin
      if (clk_h < HOURS_PER_DAY) clk_h++;
      clk_m = 0;
    end
    if (clk_h == HOURS_PER_DAY) clk_h = 0;

    r.clock_hours       = 5'(clk_h);
    r.clock_minutes     = 6'(clk_m);
    r.clock_seconds     = 6'(clk_s);
    r.countdown_hours   = 5'(cd_h);
    r.countdown_minutes = 6'(cd_m);
    r.countdown_seconds = 6'(cd_s);
    r.in_timer_mode     = timer_mode;
    r.countdown_running = cd_running;
    r.buzzer_on         = buzz_now;
    return r;
  endfunction

  function automatic in_item_t buttons(bit mi, bit hr, bit md);
    in_item_t it;
    it.minute_button = mi;
    it.hour_button   = hr;
    it.mode_button   = md;
    return it;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_tick(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_outputs.push_back(clock_tick(it));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic send_run(in_item_t it, int n);
    repeat (n) send_tick(it);
  endtask

  // One press held just long enough to be accepted, then a full release.
  task automatic press_release(in_item_t it);
    send_run(it, debounce_limit + 1);
    send_run('0, debounce_limit + 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_WAIT_COUNT) debounce_limit = 32'(val);
    else if (idx == REG_BUZZ_LENGTH) buzz_len = 32'(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly clean press and release pairs, with runs left short, idle stretches
  // that let a countdown run out, and some raw button noise.
  task automatic random_sessions(int n);
    int       target;
    int       kind;
    int       pick;
    int       hold_n;
    in_item_t lv;
    target = ticks_sent + n;
    while (ticks_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        pick = $urandom_range(99);
        if (pick < 40) lv = buttons(0, 0, 1);
        else if (pick < 70) lv = buttons(1, 0, 0);
        else if (pick < 90) lv = buttons(0, 1, 0);
        else lv = buttons(1'($urandom_range(1)), 1'($urandom_range(1)), 1);
        hold_n = debounce_limit + 1 + $urandom_range(2);
        if ($urandom_range(9) == 0 && debounce_limit > 0) hold_n = debounce_limit;
        send_run(lv, hold_n);
        send_run('0, debounce_limit + 1 + $urandom_range(2));
      end else if (kind < 85) begin
        send_run('0, $urandom_range(10, 70));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_tick(buttons(1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1))));
        end
      end
    end
  endtask

  task automatic test_buttons_and_modes();
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_WAIT_COUNT, 8'd0);
    write_reg(REG_BUZZ_LENGTH, 8'd3);
    send_tick('0);
    press_release(buttons(1, 0, 0));
    press_release(buttons(0, 1, 0));
    // All three at once: the mode switch lands first, so the others set the countdown.
    press_release(buttons(1, 1, 1));
    press_release(buttons(0, 0, 1));
    press_release(buttons(0, 0, 1));
    press_release(buttons(0, 0, 1));
    // Starting at zero expires in the same tick and sounds the buzzer.
    press_release(buttons(0, 0, 1));
    send_run('0, 4);
    settle();
  endtask

  task automatic test_rollovers();
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (22) press_release(buttons(1, 1, 0));
    while (clk_m != 59) press_release(buttons(1, 0, 0));
    while (clk_s != 59) send_tick('0);
    // This press carries the minute in the same tick as the second wraps.
    press_release(buttons(1, 0, 0));
    press_release(buttons(0, 0, 1));
    // Countdown minutes wrap past 59 while countdown hours stop at 24.
    repeat (60) press_release(buttons(1, 1, 0));
    press_release(buttons(0, 0, 1));
    send_run('0, 3);
    press_release(buttons(0, 0, 1));
    settle();
  endtask

  task automatic test_register_extremes();
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_BUZZ_LENGTH, 8'd255);
    press_release(buttons(0, 0, 1));
    press_release(buttons(0, 0, 1));
    settle();
    // With the threshold at the top of the counter range no press is ever
    // taken, even with all three buttons held while the long buzz plays.
    write_reg(REG_WAIT_COUNT, 8'd255);
    send_run(buttons(1, 1, 1), 30);
    send_run('0, 4);
    settle();
    write_reg(REG_WAIT_COUNT, 8'd1);
    write_reg(REG_BUZZ_LENGTH, 8'd0);
    press_release(buttons(0, 0, 1));
    press_release(buttons(0, 0, 1));
    send_run('0, 3);
    settle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_WAIT_COUNT, 8'd2);
    write_reg(REG_BUZZ_LENGTH, 8'd5);
    holdoff_request = HOLDOFF_LEN;
    random_sessions(40);
    settle();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_chance);
    send_idle_pct = idle_pct;
    stall_pct = stall_chance;
    write_reg(REG_WAIT_COUNT, 8'($urandom_range(0, 3)));
    write_reg(REG_BUZZ_LENGTH, 8'($urandom_range(0, 8)));
    random_sessions(20);
    settle();
  endtask

  // Receiver: random stalls, or a long hold-off counted here when requested.
  always @(negedge clk) begin
    if (holdoff_request > 0) begin
      holdoff_left = holdoff_request;
      holdoff_request = 0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_outputs.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing expected, expected none, got %p",
                 $time, out_data);
      end else begin
        want = predicted_outputs.pop_front();
        check_field("clock_hours", 32'(want.clock_hours), 32'(out_data.clock_hours));
        check_field("clock_minutes", 32'(want.clock_minutes),
                    32'(out_data.clock_minutes));
        check_field("clock_seconds", 32'(want.clock_seconds),
                    32'(out_data.clock_seconds));
        check_field("countdown_hours", 32'(want.countdown_hours),
                    32'(out_data.countdown_hours));
        check_field("countdown_minutes", 32'(want.countdown_minutes),
                    32'(out_data.countdown_minutes));
        check_field("countdown_seconds", 32'(want.countdown_seconds),
                    32'(out_data.countdown_seconds));
        check_field("in_timer_mode", 32'(want.in_timer_mode),
                    32'(out_data.in_timer_mode));
        check_field("countdown_running", 32'(want.countdown_running),
                    32'(out_data.countdown_running));
        check_field("buzzer_on", 32'(want.buzzer_on), 32'(out_data.buzzer_on));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_buttons_and_modes();
    test_rollovers();
    test_register_extremes();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(86, 0);
    test_random_traffic(0, 86);
    test_random_traffic(37, 37);
    settle();
    if (errors == 0 && predicted_outputs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
